/* design/tlpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// shared types and constants of the two-level page table engine
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int TABLE_SLOTS       = 16;
  localparam int USER_DIR_ENTRIES  = 768;
  localparam int ENTRIES_PER_TABLE = 1024;

  localparam int TIX_W     = 10;
  localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int NFS_W     = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_AW    = (USER_DIR_ENTRIES > 1) ? $clog2(USER_DIR_ENTRIES) : 1;
  localparam int DIR_W     = SLOT_W + 1;  // valid bit and slot number
  localparam int TBL_AW    = SLOT_W + TIX_W;
  localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;

  localparam logic [31:0] USER_LIMIT = 32'hC000_0000;

  // page-table entry bit positions
  localparam int PTE_PRESENT  = 0;
  localparam int PTE_WRITE    = 1;
  localparam int PTE_USER     = 2;
  localparam int PTE_ACCESSED = 5;
  localparam int PTE_DIRTY    = 6;

  // configuration register indexes
  localparam logic REG_RAM_PAGES  = 1'b0;
  localparam logic REG_DIR_ACTIVE = 1'b1;

  localparam logic [18:0] RAM_PAGES_RST = 19'd1024;

  typedef enum logic [2:0] {
    F_MAP       = 3'd0,
    F_TRANSLATE = 3'd1,
    F_CLEAR     = 3'd2,
    F_QUERY     = 3'd3,
    F_SET_DIRTY = 3'd4,
    F_SET_ACC   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_NOSLOT = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_PTE
  } state_t;

  typedef struct packed {
    logic clr_en;     // clearing pass write
    logic req_load;   // latch the accepted item
    logic dir_rd;     // directory read at the incoming address
    logic dir_stage;  // directory data valid: allocate and read the table
    logic commit;     // table write-back and output load
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

/* design/tlpt_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_cfg
// apb register file: ram_pages and directory_active
// ----------------------------------------------------------------------------
module tlpt_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [18:0] ram_pages,
  output logic        dir_active
);

  logic [18:0] ram_pages_r;
  logic        dir_active_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_pages_r  <= tlpt_pkg::RAM_PAGES_RST;
      dir_active_r <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == tlpt_pkg::REG_RAM_PAGES) begin
        ram_pages_r <= pwdata[18:0];
      end else begin
        dir_active_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == tlpt_pkg::REG_RAM_PAGES) begin
      prdata = {13'd0, ram_pages_r};
    end else begin
      prdata = {31'd0, dir_active_r};
    end
  end

  assign ram_pages  = ram_pages_r;
  assign dir_active = dir_active_r;

endmodule

/* design/tlpt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_ctrl
// sequencer: clearing pass, directory step, table step, output handshake
// ----------------------------------------------------------------------------
module tlpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tlpt_pkg::dp_stat_t   stat,
  output tlpt_pkg::ctrl_cmd_t  cmd
);

  tlpt_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpt_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tlpt_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = tlpt_pkg::S_IDLE;
        end
      end
      tlpt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          cmd.dir_rd   = 1'b1;
          state_nxt    = tlpt_pkg::S_DIR;
        end
      end
      tlpt_pkg::S_DIR: begin
        cmd.dir_stage = 1'b1;
        state_nxt     = tlpt_pkg::S_PTE;
      end
      tlpt_pkg::S_PTE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.req_load = 1'b1;
            cmd.dir_rd   = 1'b1;
            state_nxt    = tlpt_pkg::S_DIR;
          end else begin
            state_nxt = tlpt_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tlpt_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/tlpt_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_dpath
// request registers, directory and table memories, slot pool, result register
// ----------------------------------------------------------------------------
module tlpt_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlpt_pkg::ctrl_cmd_t  cmd,
  output tlpt_pkg::dp_stat_t   stat,
  input  logic [18:0]          ram_pages,
  input  logic                 dir_active,
  input  logic [2:0]           in_func,
  input  logic [31:0]          in_virt_addr,
  input  logic [17:0]          in_frame_number,
  input  logic                 in_writable,
  input  logic                 in_bit_value,
  output logic [1:0]           out_status,
  output logic [29:0]          out_phys_addr,
  output logic                 out_is_dirty,
  output logic                 out_is_accessed,
  output logic                 out_flush_tlb
);

  // request
  tlpt_pkg::func_t func_r;
  logic [31:0]     va_r;
  logic [17:0]     frame_r;
  logic            wr_r;
  logic            bv_r;

  // memories
  logic [tlpt_pkg::DIR_W-1:0] dir_mem [tlpt_pkg::USER_DIR_ENTRIES];
  logic [31:0]                tbl_mem [tlpt_pkg::TBL_DEPTH];
  logic [tlpt_pkg::DIR_W-1:0] dir_q_r;
  logic [31:0]                pte_q_r;

  logic                        dir_we;
  logic [tlpt_pkg::DIR_AW-1:0] dir_wa;
  logic [tlpt_pkg::DIR_W-1:0]  dir_wd;
  logic                        tbl_we;
  logic [tlpt_pkg::TBL_AW-1:0] tbl_wa;
  logic [31:0]                 tbl_wd;

  // clearing pass and slot pool
  logic [tlpt_pkg::TBL_AW-1:0] clr_cnt_r;
  logic [tlpt_pkg::NFS_W-1:0]  next_free_r;

  // directory step results
  logic                        have_r;
  logic                        nofree_r;
  logic                        bad_r;
  logic [tlpt_pkg::TBL_AW-1:0] tbl_addr_r;

  // decode
  logic [9:0]                  va_dir;
  logic [9:0]                  va_tix;
  logic [11:0]                 va_ofs;
  logic                        bad;
  logic                        map_args_ok;
  logic                        frame_fits;
  logic                        dir_hit;
  logic                        pool_left;
  logic                        alloc;
  logic [tlpt_pkg::SLOT_W-1:0] slot_sel;

  // table step results
  tlpt_pkg::status_t st;
  logic [31:0]       new_pte;
  logic              pte_wr;
  logic              flush;
  logic [29:0]       phys;
  logic              have_out;

  assign va_dir = va_r[31:22];
  assign va_tix = va_r[21:12];
  assign va_ofs = va_r[11:0];

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      func_r  <= tlpt_pkg::func_t'(in_func);
      va_r    <= in_virt_addr;
      frame_r <= in_frame_number;
      wr_r    <= in_writable;
      bv_r    <= in_bit_value;
    end
  end

  // directory step
  assign bad = (func_r > tlpt_pkg::F_SET_ACC) || (va_r >= tlpt_pkg::USER_LIMIT)
               || ({1'b0, va_dir} >= 11'(tlpt_pkg::USER_DIR_ENTRIES));
  assign frame_fits  = {1'b0, frame_r} < ram_pages;
  assign map_args_ok = (func_r == tlpt_pkg::F_MAP) && (va_ofs == 12'd0) && frame_fits;
  assign dir_hit     = dir_q_r[tlpt_pkg::DIR_W-1];
  assign pool_left   = next_free_r < tlpt_pkg::NFS_W'(tlpt_pkg::TABLE_SLOTS);
  assign alloc       = cmd.dir_stage && !bad && map_args_ok && !dir_hit && pool_left;
  assign slot_sel    = dir_hit ? dir_q_r[tlpt_pkg::SLOT_W-1:0]
                               : next_free_r[tlpt_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.dir_stage) begin
      have_r     <= dir_hit || (map_args_ok && pool_left && !bad);
      nofree_r   <= map_args_ok && !dir_hit && !pool_left;
      bad_r      <= bad;
      tbl_addr_r <= {slot_sel, va_tix};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= '0;
    end else if (alloc) begin
      next_free_r <= next_free_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clr_last = clr_cnt_r == tlpt_pkg::TBL_AW'(tlpt_pkg::TBL_DEPTH - 1);

  // directory memory port
  always_comb begin
    if (cmd.clr_en) begin
      dir_we = clr_cnt_r < tlpt_pkg::TBL_AW'(tlpt_pkg::USER_DIR_ENTRIES);
      dir_wa = clr_cnt_r[tlpt_pkg::DIR_AW-1:0];
      dir_wd = '0;
    end else begin
      dir_we = alloc;
      dir_wa = va_dir[tlpt_pkg::DIR_AW-1:0];
      dir_wd = {1'b1, next_free_r[tlpt_pkg::SLOT_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
  end

  // out-of-range directory indexes are rejected later, read entry zero for them
  always_ff @(posedge clk) begin
    if (cmd.dir_rd) begin
      if ({1'b0, in_virt_addr[31:22]} < 11'(tlpt_pkg::USER_DIR_ENTRIES)) begin
        dir_q_r <= dir_mem[in_virt_addr[22 +: tlpt_pkg::DIR_AW]];
      end else begin
        dir_q_r <= dir_mem[0];
      end
    end
  end

  // table step
  always_comb begin
    st      = tlpt_pkg::ST_OK;
    new_pte = pte_q_r;
    pte_wr  = 1'b0;
    flush   = 1'b0;
    phys    = '0;
    if (bad_r) begin
      st = tlpt_pkg::ST_REJECT;
    end else begin
      case (func_r)
        tlpt_pkg::F_MAP: begin
          if (va_ofs != 12'd0 || !frame_fits) begin
            st = tlpt_pkg::ST_REJECT;
          end else if (nofree_r) begin
            st = tlpt_pkg::ST_NOSLOT;
          end else if (pte_q_r[tlpt_pkg::PTE_PRESENT]) begin
            st = tlpt_pkg::ST_REJECT;
          end else begin
            new_pte = {2'b00, frame_r, 12'd0};
            new_pte[tlpt_pkg::PTE_PRESENT] = 1'b1;
            new_pte[tlpt_pkg::PTE_USER]    = 1'b1;
            new_pte[tlpt_pkg::PTE_WRITE]   = wr_r;
            pte_wr = 1'b1;
          end
        end
        tlpt_pkg::F_TRANSLATE: begin
          if (!have_r || !pte_q_r[tlpt_pkg::PTE_PRESENT]) begin
            st = tlpt_pkg::ST_ABSENT;
          end else begin
            phys = {pte_q_r[29:12], va_ofs};
          end
        end
        tlpt_pkg::F_CLEAR: begin
          if (va_ofs != 12'd0) begin
            st = tlpt_pkg::ST_REJECT;
          end else if (!have_r || !pte_q_r[tlpt_pkg::PTE_PRESENT]) begin
            st = tlpt_pkg::ST_ABSENT;
          end else begin
            new_pte[tlpt_pkg::PTE_PRESENT] = 1'b0;
            pte_wr = 1'b1;
            flush  = dir_active;
          end
        end
        tlpt_pkg::F_QUERY: begin
          if (!have_r) begin
            st = tlpt_pkg::ST_ABSENT;
          end
        end
        tlpt_pkg::F_SET_DIRTY, tlpt_pkg::F_SET_ACC: begin
          if (!have_r) begin
            st = tlpt_pkg::ST_ABSENT;
          end else begin
            pte_wr = 1'b1;
            if (func_r == tlpt_pkg::F_SET_DIRTY) begin
              new_pte[tlpt_pkg::PTE_DIRTY] = bv_r;
            end else begin
              new_pte[tlpt_pkg::PTE_ACCESSED] = bv_r;
            end
            flush = !bv_r && dir_active;
          end
        end
        default: begin
          st = tlpt_pkg::ST_REJECT;
        end
      endcase
    end
    have_out = have_r && (st != tlpt_pkg::ST_REJECT);
  end

  // table memory port
  always_comb begin
    if (cmd.clr_en) begin
      tbl_we = 1'b1;
      tbl_wa = clr_cnt_r;
      tbl_wd = '0;
    end else begin
      tbl_we = cmd.commit && pte_wr;
      tbl_wa = tbl_addr_r;
      tbl_wd = new_pte;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dir_stage) begin
      tbl_q_read: begin
        pte_q_r <= tbl_mem[{slot_sel, va_tix}];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status      <= st;
      out_phys_addr   <= phys;
      out_is_dirty    <= have_out && new_pte[tlpt_pkg::PTE_DIRTY];
      out_is_accessed <= have_out && new_pte[tlpt_pkg::PTE_ACCESSED];
      out_flush_tlb   <= flush;
    end
  end

endmodule

/* design/two_level_page_table_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// user page table of one process in the 10/10/12 two-level x86 layout
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 16384 table words (one
// table word a cycle, the 768 directory entries along with the first of them)
// and takes no item until it ends; register writes are taken throughout. An
// item's directory entry is read at the edge that accepts it, the next cycle
// allocates a slot if needed and reads the page-table entry, and the table
// step then writes the entry back and loads the result register, and may
// accept the next item at the same time. So a new item is taken only once
// the previous one has reached its table step, since the table read follows
// the directory read on the single-port memories. A held result register
// stalls the table step until the result is taken.
// ----------------------------------------------------------------------------
module two_level_page_table_engine (
  input  logic        clk,
  input  logic        rst_n,

  // request items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_virt_addr,
  input  logic [17:0] in_frame_number,
  input  logic        in_writable,
  input  logic        in_bit_value,

  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [29:0] out_phys_addr,
  output logic        out_is_dirty,
  output logic        out_is_accessed,
  output logic        out_flush_tlb,

  // register port: ram_pages at 0x0, directory_active at 0x4
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tlpt_pkg::ctrl_cmd_t cmd;
  tlpt_pkg::dp_stat_t  stat;
  logic [18:0]         ram_pages;
  logic                dir_active;

  // configuration registers
  tlpt_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ram_pages  (ram_pages),
    .dir_active (dir_active)
  );

  // sequencer and output handshake
  tlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memories, slot pool and the per-func result logic
  tlpt_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .ram_pages       (ram_pages),
    .dir_active      (dir_active),
    .in_func         (in_func),
    .in_virt_addr    (in_virt_addr),
    .in_frame_number (in_frame_number),
    .in_writable     (in_writable),
    .in_bit_value    (in_bit_value),
    .out_status      (out_status),
    .out_phys_addr   (out_phys_addr),
    .out_is_dirty    (out_is_dirty),
    .out_is_accessed (out_is_accessed),
    .out_flush_tlb   (out_flush_tlb)
  );

endmodule
